/* hw/rtl/qtlc_pkg.sv */
`default_nettype none

package qtlc_pkg;

	localparam int CODE_W = 64;
	localparam int KEY_W  = 32;
	localparam int REG_W  = 32;
	localparam int IDX_W  = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_X_LOW  = 2'd0,
		REG_X_HIGH = 2'd1,
		REG_Y_LOW  = 2'd2,
		REG_Y_HIGH = 2'd3
	} reg_idx_t;

	// reset box: -180.0 .. 180.0 by -90.0 .. 90.0, Q16.16
	localparam logic signed [REG_W-1:0] X_LOW_RST  = -32'sd11796480;
	localparam logic signed [REG_W-1:0] X_HIGH_RST = 32'sd11796480;
	localparam logic signed [REG_W-1:0] Y_LOW_RST  = -32'sd5898240;
	localparam logic signed [REG_W-1:0] Y_HIGH_RST = 32'sd5898240;

endpackage

`default_nettype wire

/* hw/rtl/quadtree_location_code.sv */
`default_nettype none

// channel  dir  signals                              item
// s_*      in   s_tvalid s_tready s_tdata s_tlast    one point
// m_*      out  m_tvalid m_tready m_tdata m_tuser    one location code
//                                 m_tlast
// wr_*     in   wr_en wr_index wr_data               box edge write
//
// One point per cycle unless the output stalls. Register stages: edge ordering,
// clamp and offset, then one register stage per quadtree level.
// arst_n clears the valid bits and loads the default box.
// A stall at the output holds every stage at once, bubbles included:
// s_tready is low exactly while an item waits at the output unaccepted.

module quadtree_location_code
	import qtlc_pkg::*;
#(
	parameter int DEPTH       = 32,
	parameter int COORD_WIDTH = 32,
	localparam int IN_W       = ((2 * COORD_WIDTH + KEY_W + 7) / 8) * 8,
	localparam int OUT_W      = CODE_W + KEY_W
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_W-1:0]        s_tdata,   // x_coord, y_coord, point_key, zero pad
	input  wire logic                   s_tlast,   // last_point

	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_W-1:0]            m_tdata,   // location_code, key_out
	output logic                        m_tuser,   // clamped
	output logic                        m_tlast,   // last_out

	input  wire logic                   wr_en,
	input  wire logic [IDX_W-1:0]       wr_index,
	input  wire logic [COORD_WIDTH-1:0] wr_data
);

	localparam int CW = COORD_WIDTH;
	localparam int LW = 2 * DEPTH;

	logic signed [CW-1:0] x_low_q, x_high_q, y_low_q, y_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= CW'(X_LOW_RST);
			x_high_q <= CW'(X_HIGH_RST);
			y_low_q  <= CW'(Y_LOW_RST);
			y_high_q <= CW'(Y_HIGH_RST);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_X_LOW:  x_low_q  <= wr_data;
				REG_X_HIGH: x_high_q <= wr_data;
				REG_Y_LOW:  y_low_q  <= wr_data;
				REG_Y_HIGH: y_high_q <= wr_data;
				default: ;
			endcase
		end
	end

	logic en;

	logic signed [CW-1:0] in_x, in_y;
	logic [KEY_W-1:0]     in_key;

	assign in_x   = s_tdata[CW-1:0];
	assign in_y   = s_tdata[2*CW-1:CW];
	assign in_key = s_tdata[2*CW+KEY_W-1:2*CW];

	// stage 1: order the edges
	logic                 v_s1;
	logic signed [CW-1:0] px_s1, py_s1, xlo_s1, xhi_s1, ylo_s1, yhi_s1;
	logic [KEY_W-1:0]     key_s1;
	logic                 last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= in_x;
			py_s1   <= in_y;
			key_s1  <= in_key;
			last_s1 <= s_tlast;
			if (x_low_q > x_high_q) begin
				xlo_s1 <= x_high_q;
				xhi_s1 <= x_low_q;
			end else begin
				xlo_s1 <= x_low_q;
				xhi_s1 <= x_high_q;
			end
			if (y_low_q > y_high_q) begin
				ylo_s1 <= y_high_q;
				yhi_s1 <= y_low_q;
			end else begin
				ylo_s1 <= y_low_q;
				yhi_s1 <= y_high_q;
			end
		end
	end

	// stage 2: clamp, then work on offset from low edge and box width
	logic [CW-1:0] dx_c, dy_c, ox_c, oy_c, rx_c, ry_c;
	logic          xb_c, xa_c, yb_c, ya_c;

	always_comb begin
		dx_c = xhi_s1 - xlo_s1;
		dy_c = yhi_s1 - ylo_s1;
		ox_c = px_s1 - xlo_s1;
		oy_c = py_s1 - ylo_s1;
		xb_c = px_s1 < xlo_s1;
		xa_c = px_s1 > xhi_s1;
		yb_c = py_s1 < ylo_s1;
		ya_c = py_s1 > yhi_s1;
		rx_c = xb_c ? '0 : (xa_c ? dx_c : ox_c);
		ry_c = yb_c ? '0 : (ya_c ? dy_c : oy_c);
	end

	logic             v_l   [DEPTH+1];
	logic [CW-1:0]    rx_l  [DEPTH+1];
	logic [CW-1:0]    dx_l  [DEPTH+1];
	logic [CW-1:0]    ry_l  [DEPTH+1];
	logic [CW-1:0]    dy_l  [DEPTH+1];
	logic [LW-1:0]    code_l[DEPTH+1];
	logic [KEY_W-1:0] key_l [DEPTH+1];
	logic             clmp_l[DEPTH+1];
	logic             last_l[DEPTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_l[0] <= 1'b0;
		end else if (en) begin
			v_l[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_l[0]   <= rx_c;
			dx_l[0]   <= dx_c;
			ry_l[0]   <= ry_c;
			dy_l[0]   <= dy_c;
			code_l[0] <= '0;
			key_l[0]  <= key_s1;
			clmp_l[0] <= xb_c | xa_c | yb_c | ya_c;
			last_l[0] <= last_s1;
		end
	end

	// one stage per level: bit = offset above half width
	for (genvar k = 0; k < DEPTH; k++) begin : g_lvl
		localparam int POS = 2 * (DEPTH - 1 - k);

		logic [CW-1:0] hx, hy;
		logic          bx, by;
		logic [LW-1:0] code_n;

		always_comb begin
			hx = dx_l[k] >> 1;
			hy = dy_l[k] >> 1;
			bx = rx_l[k] > hx;
			by = ry_l[k] > hy;
			code_n = code_l[k];
			code_n[POS+1] = by;
			code_n[POS]   = bx;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_l[k+1] <= 1'b0;
			end else if (en) begin
				v_l[k+1] <= v_l[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_l[k+1]   <= bx ? rx_l[k] - hx : rx_l[k];
				dx_l[k+1]   <= bx ? dx_l[k] - hx : hx;
				ry_l[k+1]   <= by ? ry_l[k] - hy : ry_l[k];
				dy_l[k+1]   <= by ? dy_l[k] - hy : hy;
				code_l[k+1] <= code_n;
				key_l[k+1]  <= key_l[k];
				clmp_l[k+1] <= clmp_l[k];
				last_l[k+1] <= last_l[k];
			end
		end
	end

	assign en       = m_tready | ~v_l[DEPTH];
	assign s_tready = en;
	assign m_tvalid = v_l[DEPTH];
	assign m_tdata  = {key_l[DEPTH], CODE_W'(code_l[DEPTH])};
	assign m_tuser  = clmp_l[DEPTH];
	assign m_tlast  = last_l[DEPTH];

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import qtlc_pkg::*;

	localparam int LEVELS = 32;
	localparam int XY_W = 32;
	localparam int LATENCY = LEVELS + 2;
	localparam longint CYCLE_LIMIT = 300000;
	localparam int RANDOM_PER_MODE = 62;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [KEY_W-1:0]  key;
		logic              clamped;
		logic              last;
	} loc_result_t;

	typedef struct packed {
		logic [XY_W-1:0]   x;
		logic [XY_W-1:0]   y;
		logic [KEY_W-1:0]  key;
		logic              last;
		logic              typed;
		logic [CODE_W-1:0] code;
		logic              clamped;
	} probe_row_t;

	// reset box: x -180.0 .. 180.0, y -90.0 .. 90.0
	localparam probe_row_t PROBES [14] = '{
		'{32'hFF4C0000, 32'hFFA60000, 32'h00000000, 1'b0, 1'b1, 64'h0, 1'b0},
		'{32'h00B40000, 32'h005A0000, 32'hFFFFFFFF, 1'b1, 1'b1, {64{1'b1}}, 1'b0},
		'{32'h80000000, 32'h80000000, 32'h5A5AA5A5, 1'b0, 1'b1, 64'h0, 1'b1},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'hA5A55A5A, 1'b1, 1'b1, {64{1'b1}}, 1'b1},
		'{32'h00B40000, 32'hFFA60000, 32'h00000001, 1'b0, 1'b1, {32{2'b01}}, 1'b0},
		'{32'hFF4C0000, 32'h005A0000, 32'h00000002, 1'b0, 1'b1, {32{2'b10}}, 1'b0},
		'{32'h7FFFFFFF, 32'h80000000, 32'h00000003, 1'b1, 1'b1, {32{2'b01}}, 1'b1},
		'{32'h80000000, 32'h7FFFFFFF, 32'h00000004, 1'b0, 1'b1, {32{2'b10}}, 1'b1},
		'{32'h00000000, 32'h00000000, 32'h00000005, 1'b0, 1'b0, 64'h0, 1'b0},
		'{32'h00000001, 32'h00000001, 32'h00000006, 1'b0, 1'b0, 64'h0, 1'b0},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000007, 1'b1, 1'b0, 64'h0, 1'b0},
		'{32'h00B40001, 32'h00000000, 32'h00000008, 1'b0, 1'b0, 64'h0, 1'b0},
		'{32'hFF4BFFFF, 32'hFFA5FFFF, 32'h00000009, 1'b0, 1'b0, 64'h0, 1'b0},
		'{32'h12345678, 32'h0FEDCBA9, 32'hDEADBEEF, 1'b1, 1'b0, 64'h0, 1'b0}
	};

	// x_low, x_high, y_low, y_high
	localparam logic [XY_W-1:0] BOXES [4][4] = '{
		'{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
		'{32'h00640000, 32'hFF9C0000, 32'h7FFFFFFF, 32'h80000000},
		'{32'h00010000, 32'h00010000, 32'hFFFF0000, 32'hFFFF0000},
		'{32'h00000000, 32'h00000001, 32'h00000000, 32'h00000003}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [2*XY_W+KEY_W-1:0] s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [CODE_W+KEY_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 wr_en = 1'b0;
	logic [IDX_W-1:0]     wr_index = '0;
	logic [XY_W-1:0]      wr_data = '0;

	logic signed [XY_W-1:0] box_edge [4];
	loc_result_t pending_codes [$];
	int     errors = 0;
	longint cycle = 0;
	longint hold_until = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;

	quadtree_location_code #(
		.DEPTH(LEVELS),
		.COORD_WIDTH(XY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (cycle < hold_until)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic loc_result_t locate_point(logic [XY_W-1:0] x, logic [XY_W-1:0] y,
			logic [KEY_W-1:0] key, logic last);
		longint p [2];
		longint lo [2];
		longint hi [2];
		longint mid;
		longint t;
		loc_result_t r;
		p[0] = $signed(x);
		p[1] = $signed(y);
		lo[0] = box_edge[REG_X_LOW];
		hi[0] = box_edge[REG_X_HIGH];
		lo[1] = box_edge[REG_Y_LOW];
		hi[1] = box_edge[REG_Y_HIGH];
		r.code = '0;
		r.clamped = 1'b0;
		for (int a = 0; a < 2; a++) begin
			if (lo[a] > hi[a]) begin
				t = lo[a];
				lo[a] = hi[a];
				hi[a] = t;
			end
			if (p[a] < lo[a]) begin
				p[a] = lo[a];
				r.clamped = 1'b1;
			end else if (p[a] > hi[a]) begin
				p[a] = hi[a];
				r.clamped = 1'b1;
			end
		end
		// y bit first, then x; the box follows the bit
		for (int lvl = 0; lvl < LEVELS; lvl++) begin
			for (int a = 1; a >= 0; a--) begin
				mid = lo[a] + ((hi[a] - lo[a]) >> 1);
				if (p[a] > mid)
					lo[a] = mid;
				else
					hi[a] = mid;
				r.code = {r.code[CODE_W-2:0], p[a] > mid};
			end
		end
		r.key = key;
		r.last = last;
		return r;
	endfunction

	function automatic logic [XY_W-1:0] pick_coord(longint lo, longint hi);
		logic [63:0] r;
		longint t;
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		case ($urandom_range(9))
			0, 1: t = $urandom;
			2: begin
				case ($urandom_range(4))
					0: t = lo;
					1: t = hi;
					2: t = lo + ((hi - lo) >> 1);
					3: t = lo + ((hi - lo) >> 1) + 1;
					default: t = lo - 1;
				endcase
			end
			default: begin
				r = {$urandom, $urandom};
				t = lo - 4 + longint'(r % (hi - lo + 9));
			end
		endcase
		return t[XY_W-1:0];
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (errors < 40)
			$display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		loc_result_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_codes.size() == 0) begin
				report_mismatch("unrequested item, code", m_tdata[CODE_W-1:0], '0);
			end else begin
				due = pending_codes.pop_front();
				if (m_tdata[CODE_W-1:0] !== due.code)
					report_mismatch("location_code", m_tdata[CODE_W-1:0], due.code);
				if (m_tdata[CODE_W+KEY_W-1:CODE_W] !== due.key)
					report_mismatch("key_out", m_tdata[CODE_W+KEY_W-1:CODE_W], due.key);
				if (m_tuser !== due.clamped)
					report_mismatch("clamped", m_tuser, due.clamped);
				if (m_tlast !== due.last)
					report_mismatch("last_out", m_tlast, due.last);
			end
		end
	end

	task automatic send_point(input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
			input logic [KEY_W-1:0] key, input logic last,
			input logic typed, input logic [CODE_W-1:0] code, input logic clamped);
		loc_result_t due;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {key, y, x};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		due = locate_point(x, y, key, last);
		if (typed) begin
			due.code = code;
			due.clamped = clamped;
		end
		pending_codes.push_back(due);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_point(pick_coord(box_edge[REG_X_LOW], box_edge[REG_X_HIGH]),
				pick_coord(box_edge[REG_Y_LOW], box_edge[REG_Y_HIGH]),
				$urandom, $urandom_range(7) == 0, 1'b0, '0, 1'b0);
	endtask

	task automatic settle_pipeline;
		s_tvalid <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_box(input logic [XY_W-1:0] edges [4]);
		for (int i = 0; i < 4; i++) begin
			wr_en <= 1'b1;
			wr_index <= i[IDX_W-1:0];
			wr_data <= edges[i];
			@(posedge clk);
			box_edge[i] = edges[i];
		end
		wr_en <= 1'b0;
	endtask

	task automatic send_box_edges;
		logic [XY_W-1:0] xv [5];
		logic [XY_W-1:0] yv [5];
		longint lo;
		longint hi;
		lo = box_edge[REG_X_LOW];
		hi = box_edge[REG_X_HIGH];
		xv = '{lo[XY_W-1:0], hi[XY_W-1:0], 32'h80000000, 32'h7FFFFFFF, 32'h0};
		xv[4] = pick_coord(lo, lo);
		lo = box_edge[REG_Y_LOW];
		hi = box_edge[REG_Y_HIGH];
		yv = '{lo[XY_W-1:0], hi[XY_W-1:0], 32'h80000000, 32'h7FFFFFFF, 32'h0};
		yv[4] = pick_coord(hi, hi);
		for (int i = 0; i < 5; i++) begin
			send_point(xv[i], yv[i], $urandom, 1'b0, 1'b0, '0, 1'b0);
			send_point(xv[i], yv[(i + 2) % 5], $urandom, 1'b1, 1'b0, '0, 1'b0);
		end
	endtask

	initial begin
		logic [XY_W-1:0] edges [4];
		box_edge[REG_X_LOW] = X_LOW_RST;
		box_edge[REG_X_HIGH] = X_HIGH_RST;
		box_edge[REG_Y_LOW] = Y_LOW_RST;
		box_edge[REG_Y_HIGH] = Y_HIGH_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PROBES[i])
			send_point(PROBES[i].x, PROBES[i].y, PROBES[i].key, PROBES[i].last,
				PROBES[i].typed, PROBES[i].code, PROBES[i].clamped);
		settle_pipeline();

		// long output hold while points keep coming: pipeline fills, input stalls
		hold_until = cycle + 400;
		send_random(90);
		settle_pipeline();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				if (phase < 5)
					edges = BOXES[phase - 1];
				else
					edges = '{$urandom, $urandom, $urandom, $urandom};
				write_box(edges);
			end
			send_box_edges();
			for (int mode = 0; mode < 4; mode++) begin
				send_idle_pct = (mode == 1) ? 66 : (mode == 3) ? 31 : 0;
				recv_stall_pct = (mode == 2) ? 66 : (mode == 3) ? 31 : 0;
				send_random(RANDOM_PER_MODE);
			end
			send_idle_pct = 0;
			recv_stall_pct = 0;
			settle_pipeline();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
